// ===== hdl/rtp_jb_pkg.sv =====
// Shared types, widths and codes for the RTP jitter buffer.
package rtp_jb_pkg;

  // Slot count; the slot index is the low bits of the sequence, so a power of two.
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int PEND_W     = $clog2(SLOT_COUNT + 1);

  localparam int SEQ_W      = 16;
  localparam int TS_W       = 32;
  localparam int PAY_W      = 64;
  localparam int BYTES_W    = 13;
  localparam int PREBUF_W   = 4;
  localparam int STATUS_W   = 4;
  localparam int DEPTH_W    = 4;
  localparam int DROP_W     = 32;
  localparam int ACTION_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Slot entry in memory: {sequence, timestamp, payload}
  localparam int SLOT_DATA_W = SEQ_W + TS_W + PAY_W;

  localparam logic [BYTES_W-1:0]  EXPECTED_BYTES_RST = BYTES_W'(640);
  localparam logic [BYTES_W-1:0]  MAX_BYTES_RST      = BYTES_W'(640);
  localparam logic [PREBUF_W-1:0] PREBUF_RST         = PREBUF_W'(3);

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_PLAYOUT = 2'd1,
    ACT_FLUSH   = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED_BYTES = 2'd0,
    CFG_MAX_BYTES      = 2'd1,
    CFG_PREBUF         = 2'd2
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED       = 4'd0,
    ST_STORED_SYNC  = 4'd1,
    ST_STORED_EVICT = 4'd2,
    ST_REJECTED     = 4'd3,
    ST_LATE         = 4'd4,
    ST_DUPLICATE    = 4'd5,
    ST_FRAME        = 4'd6,
    ST_MISSING      = 4'd7,
    ST_BUFFERING    = 4'd8,
    ST_FLUSHED      = 4'd9
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_t;

endpackage

// ===== hdl/rtp_jb_frame_if.sv =====
// Request channel carrying one action with its frame fields.
interface rtp_jb_frame_if;
  logic                           valid;
  logic                           ready;
  logic [rtp_jb_pkg::ACTION_W-1:0] action;
  logic [rtp_jb_pkg::SEQ_W-1:0]    sequence_req;
  logic                           has_sequence;
  logic [rtp_jb_pkg::TS_W-1:0]     timestamp;
  logic [rtp_jb_pkg::BYTES_W-1:0]  frame_len;
  logic [rtp_jb_pkg::PAY_W-1:0]    payload;

  modport source (output valid, action, sequence_req, has_sequence, timestamp,
                  frame_len, payload, input ready);
  modport sink   (input valid, action, sequence_req, has_sequence, timestamp,
                  frame_len, payload, output ready);
endinterface

// ===== hdl/rtp_jb_result_if.sv =====
// Result channel: status, played frame and counters.
interface rtp_jb_result_if;
  logic                            valid;
  logic                            ready;
  logic [rtp_jb_pkg::STATUS_W-1:0] status;
  logic [rtp_jb_pkg::SEQ_W-1:0]    out_sequence;
  logic [rtp_jb_pkg::TS_W-1:0]     out_timestamp;
  logic [rtp_jb_pkg::PAY_W-1:0]    out_payload;
  logic [rtp_jb_pkg::DEPTH_W-1:0]  pending_depth;
  logic [rtp_jb_pkg::DROP_W-1:0]   drop_total;

  modport source (output valid, status, out_sequence, out_timestamp, out_payload,
                  pending_depth, drop_total, input ready);
  modport sink   (input valid, status, out_sequence, out_timestamp, out_payload,
                  pending_depth, drop_total, output ready);
endinterface

// ===== hdl/rtp_jb_cfg_if.sv =====
// Register write channel.
interface rtp_jb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rtp_jb_pkg::CFG_IDX_W-1:0]  index;
  logic [rtp_jb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/rtp_jb_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
module rtp_jb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/rtp_jitter_buffer_top.sv =====
// RTP jitter buffer: reorder store and playout control over a slot memory.
//
//  channel  dir  handshake      contents
//  frame    in   valid/ready    action, sequence_req, has_sequence, timestamp,
//                               frame_len, payload
//  result   out  valid/ready    status, out_sequence, out_timestamp, out_payload,
//                               pending_depth, drop_total
//  cfg      in   valid/ready    index, data (ready always high)
//
// For each request the slot memory is read when the request is accepted, and the
// execute state does the update, the memory write-back and the result register load.
// A request is accepted only in idle, so a write-back never overlaps a read.
// If the result register is still full, the update waits until it is taken.
// Reset is synchronous: slot valid bits, counters, control state and result valid are reset.
module rtp_jitter_buffer_top (
  input  logic          clk,
  input  logic          rst,
  rtp_jb_frame_if.sink  frame,
  rtp_jb_result_if.source result,
  rtp_jb_cfg_if.sink    cfg
);
  import rtp_jb_pkg::*;

  fsm_t state, state_next;

  // configuration
  logic [BYTES_W-1:0]  expected_bytes;
  logic [BYTES_W-1:0]  max_bytes;
  logic [PREBUF_W-1:0] prebuf;

  // control state
  logic [SLOT_COUNT-1:0] slot_valid, slot_valid_next;
  logic [PEND_W-1:0]     pending_count, pending_count_next;
  logic                  is_buffering, is_buffering_next;
  logic                  next_known, next_known_next;
  logic [SEQ_W-1:0]      next_expected, next_expected_next;
  logic [DROP_W-1:0]     drop_counter, drop_counter_next;

  // captured request
  logic [ACTION_W-1:0] item_action;
  logic [SEQ_W-1:0]    item_seq;
  logic                item_has_seq;
  logic [TS_W-1:0]     item_ts;
  logic [BYTES_W-1:0]  item_bytes;
  logic [PAY_W-1:0]    item_payload;

  // result register
  logic                res_valid;
  status_t             res_status, res_status_next;
  logic [SEQ_W-1:0]    res_seq, res_seq_next;
  logic [TS_W-1:0]     res_ts, res_ts_next;
  logic [PAY_W-1:0]    res_payload, res_payload_next;

  // memory
  logic                   ram_wr_en;
  logic [SLOT_W-1:0]      ram_wr_addr;
  logic [SLOT_DATA_W-1:0] ram_wr_data;
  logic                   ram_rd_en;
  logic [SLOT_W-1:0]      ram_rd_addr;
  logic [SLOT_DATA_W-1:0] ram_rd_data;
  logic [SEQ_W-1:0]       rd_seq;
  logic [TS_W-1:0]        rd_ts;
  logic [PAY_W-1:0]       rd_payload;

  logic frame_acc;
  logic res_free;
  logic commit;
  logic [SEQ_W-1:0] seq_auto;
  logic [SEQ_W-1:0] seq_in;

  assign frame_acc = frame.valid && frame.ready;
  assign res_free  = !res_valid || result.ready;
  assign commit    = (state == S_EXEC) && res_free;

  // sequence given to a frame that carries none
  assign seq_auto = next_known ? (next_expected + SEQ_W'(pending_count)) : '0;
  assign seq_in   = frame.has_sequence ? frame.sequence_req : seq_auto;

  assign {rd_seq, rd_ts, rd_payload} = ram_rd_data;

  rtp_jb_ram #(
    .WIDTH (SLOT_DATA_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (frame_acc) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    frame.ready = 1'b0;
    ram_rd_en   = 1'b0;
    unique case (state)
      S_IDLE: begin
        frame.ready = 1'b1;
        ram_rd_en   = frame.valid;
      end
      S_EXEC: begin
        frame.ready = 1'b0;
        ram_rd_en   = 1'b0;
      end
      default: ;
    endcase
  end

  assign ram_rd_addr = (frame.action == ACT_PLAYOUT) ? next_expected[SLOT_W-1:0]
                                                     : seq_in[SLOT_W-1:0];

  // update of the buffer state for the captured request
  always_comb begin
    logic [SEQ_W-1:0]  seq_e;
    logic [SEQ_W-1:0]  ne_base;
    logic [SEQ_W-1:0]  diff;
    logic              len_bad;
    logic              late;
    logic              resync;
    logic [SLOT_W-1:0] idx;
    logic              occ;

    slot_valid_next    = slot_valid;
    pending_count_next = pending_count;
    is_buffering_next  = is_buffering;
    next_known_next    = next_known;
    next_expected_next = next_expected;
    drop_counter_next  = drop_counter;
    res_status_next    = ST_REJECTED;
    res_seq_next       = '0;
    res_ts_next        = '0;
    res_payload_next   = '0;
    ram_wr_en          = 1'b0;

    seq_e   = item_has_seq ? item_seq : seq_auto;
    ne_base = next_known ? next_expected : seq_e;
    diff    = seq_e - ne_base;
    len_bad = (item_bytes == '0) || (item_bytes != expected_bytes) ||
              (item_bytes > max_bytes);
    late    = !is_buffering && diff[SEQ_W-1];
    resync  = !is_buffering && !diff[SEQ_W-1] && (diff >= SEQ_W'(SLOT_COUNT));
    idx     = (item_action == ACT_PLAYOUT) ? next_expected[SLOT_W-1:0]
                                           : seq_e[SLOT_W-1:0];
    occ     = slot_valid[idx] && !resync;

    ram_wr_addr = idx;
    ram_wr_data = {seq_e, item_ts, item_payload};

    case (item_action)
      ACT_ENQUEUE: begin
        if (len_bad) begin
          res_status_next = ST_REJECTED;
        end else begin
          next_known_next    = 1'b1;
          next_expected_next = ne_base;
          if (late) begin
            res_status_next = ST_LATE;
          end else begin
            res_status_next = ST_STORED;
            if (resync) begin
              slot_valid_next    = '0;
              pending_count_next = '0;
              is_buffering_next  = 1'b1;
              next_expected_next = seq_e;
              drop_counter_next  = drop_counter_next + 1'b1;
              res_status_next    = ST_STORED_SYNC;
            end
            if (occ && (rd_seq == seq_e)) begin
              res_status_next = ST_DUPLICATE;
            end else begin
              if (occ) begin
                if (pending_count_next != '0) begin
                  pending_count_next = pending_count_next - 1'b1;
                end
                drop_counter_next = drop_counter_next + 1'b1;
                res_status_next   = ST_STORED_EVICT;
              end
              slot_valid_next[idx] = 1'b1;
              pending_count_next   = pending_count_next + 1'b1;
              ram_wr_en            = commit;
              if (is_buffering_next &&
                  (SEQ_W'(pending_count_next) >= SEQ_W'(prebuf))) begin
                is_buffering_next = 1'b0;
              end
            end
          end
        end
      end
      ACT_PLAYOUT: begin
        if ((!next_known || is_buffering) &&
            !(next_known && (SEQ_W'(pending_count) >= SEQ_W'(prebuf)))) begin
          res_status_next = ST_BUFFERING;
        end else begin
          is_buffering_next = 1'b0;
          if (slot_valid[idx] && (rd_seq == next_expected)) begin
            res_status_next      = ST_FRAME;
            res_seq_next         = rd_seq;
            res_ts_next          = rd_ts;
            res_payload_next     = rd_payload;
            slot_valid_next[idx] = 1'b0;
            if (pending_count != '0) begin
              pending_count_next = pending_count - 1'b1;
            end
            next_expected_next = next_expected + 1'b1;
          end else if (pending_count == '0) begin
            // underrun: rebuffer and relearn the sequence
            is_buffering_next = 1'b1;
            next_known_next   = 1'b0;
            res_status_next   = ST_BUFFERING;
          end else begin
            next_expected_next = next_expected + 1'b1;
            res_status_next    = ST_MISSING;
          end
        end
      end
      ACT_FLUSH: begin
        slot_valid_next    = '0;
        pending_count_next = '0;
        is_buffering_next  = 1'b1;
        next_known_next    = 1'b0;
        next_expected_next = '0;
        drop_counter_next  = '0;
        res_status_next    = ST_FLUSHED;
      end
      default: res_status_next = ST_REJECTED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_valid    <= '0;
      pending_count <= '0;
      is_buffering  <= 1'b1;
      next_known    <= 1'b0;
      next_expected <= '0;
      drop_counter  <= '0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        slot_valid    <= slot_valid_next;
        pending_count <= pending_count_next;
        is_buffering  <= is_buffering_next;
        next_known    <= next_known_next;
        next_expected <= next_expected_next;
        drop_counter  <= drop_counter_next;
        res_valid     <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_bytes <= EXPECTED_BYTES_RST;
      max_bytes      <= MAX_BYTES_RST;
      prebuf         <= PREBUF_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_EXPECTED_BYTES: expected_bytes <= cfg.data[BYTES_W-1:0];
        CFG_MAX_BYTES:      max_bytes      <= cfg.data[BYTES_W-1:0];
        CFG_PREBUF:         prebuf         <= cfg.data[PREBUF_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (frame_acc) begin
      item_action  <= frame.action;
      item_seq     <= frame.sequence_req;
      item_has_seq <= frame.has_sequence;
      item_ts      <= frame.timestamp;
      item_bytes   <= frame.frame_len;
      item_payload <= frame.payload;
    end
    if (commit) begin
      res_status  <= res_status_next;
      res_seq     <= res_seq_next;
      res_ts      <= res_ts_next;
      res_payload <= res_payload_next;
    end
  end

  assign cfg.ready            = 1'b1;
  assign result.valid         = res_valid;
  assign result.status        = res_status;
  assign result.out_sequence  = res_seq;
  assign result.out_timestamp = res_ts;
  assign result.out_payload   = res_payload;
  assign result.pending_depth = DEPTH_W'(pending_count);
  assign result.drop_total    = drop_counter;

endmodule
